// ===== sv/bcr_pkg.sv =====
// ----------------------------------------------------------------------------
// bcr_pkg
// Shared types and constants for the Bresenham circle rasterizer.
// ----------------------------------------------------------------------------
package bcr_pkg;

  localparam int unsigned DISPLAY_WIDTH  = 320;
  localparam int unsigned DISPLAY_HEIGHT = 240;

  localparam int unsigned COORD_W = 10;
  localparam int unsigned COLOR_W = 8;
  localparam int unsigned PIX_W   = 12;
  localparam int unsigned OFSX_W  = 11;
  localparam int unsigned OFSY_W  = 12;
  localparam int unsigned DEC_W   = 14;

  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 40;
  localparam int unsigned OUT_TUSER_W = 3;

  localparam logic [DEC_W-1:0] DEC_INIT = DEC_W'(3);
  localparam logic [DEC_W-1:0] DEC_DIAG = DEC_W'(10);
  localparam logic [DEC_W-1:0] DEC_AXIS = DEC_W'(6);
  localparam logic [8:0]       COLOR_MAX = 9'd255;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BOUNDS = 2'd1,
    ST_COLOR  = 2'd2,
    ST_IDLE   = 2'd3
  } status_t;

  typedef struct packed {
    status_t              status;
    logic                 err;
    logic [COORD_W-1:0]   cx;
    logic [COORD_W-1:0]   cy;
    logic [OFSX_W-1:0]    ofs_x;
    logic [OFSY_W-1:0]    ofs_y;
    logic [COLOR_W-1:0]   color;
    logic                 done;
  } job_t;

endpackage

// ===== sv/bresenham_circle_raster.sv =====
// ----------------------------------------------------------------------------
// bresenham_circle_raster
// Bresenham circle rasterizer emitting eight symmetric pixels per request.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : request stream. in_tuser is the command (start or step), in_tdata
//           carries center, radius and color. The circle state (offsets and
//           decision value) is updated in the cycle a request is accepted.
//   out_* : result stream. A valid request yields eight pixel results, an
//           error request yields one status result; out_tlast marks the final
//           result of each request.
// Path: an accepted request is registered in the holding register, then
//   moves to the emit stage, and each result is registered at the output.
// Throughput: one result per cycle from a single emit counter when the output
//   is free; eight per pixel request, one per error request. One request
//   waits in a holding register while the previous one is emitted.
// Reset: clears the circle state, the holding register and the output valid.
// Stall: while out_tready is low the output register holds; the holding
//   register fills and in_tready drops until the emitter moves on.
// ----------------------------------------------------------------------------
module bresenham_circle_raster (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // center_x[9:0], center_y[19:10], radius[29:20], color[38:30]
  input  logic [bcr_pkg::IN_TDATA_W-1:0]     in_tdata,
  // cmd
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // pixel_x[11:0], pixel_y[23:12], pixel_color[31:24], on_screen[32],
  // circle_done[33]
  output logic [bcr_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // status[1:0], pixel_valid[2]
  output logic [bcr_pkg::OUT_TUSER_W-1:0]    out_tuser,
  output logic                               out_tlast
);
  import bcr_pkg::*;

  // circle state
  logic                 active_r, active_nxt;
  logic [OFSX_W-1:0]    ofs_x_r, ofs_x_nxt;
  logic [OFSY_W-1:0]    ofs_y_r, ofs_y_nxt;
  logic [DEC_W-1:0]     dec_r, dec_nxt;
  logic [COORD_W-1:0]   cx_r, cx_nxt;
  logic [COORD_W-1:0]   cy_r, cy_nxt;
  logic [COLOR_W-1:0]   color_r, color_nxt;

  // holding and emit stages
  logic                 pend_v_r, pend_v_nxt;
  job_t                 pend_r, pend_nxt;
  logic                 cur_v_r, cur_v_nxt;
  job_t                 cur_r, cur_nxt;
  logic [2:0]           idx_r, idx_nxt;

  // output register
  logic                 out_v_r, out_v_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic [OUT_TUSER_W-1:0] out_user_r, out_user_nxt;
  logic                 out_last_r, out_last_nxt;

  logic                 accept;
  logic [COORD_W-1:0]   in_cx, in_cy, in_rad;
  logic [8:0]           in_col;

  logic [DEC_W-1:0]     x_w, y_w;
  logic                 dec_pos;
  logic [OFSX_W-1:0]    step_x;
  logic [OFSY_W-1:0]    step_y;
  logic                 step_done;
  job_t                 job;

  logic                 fire, emit_last, load_cur;
  logic [PIX_W-1:0]     x12, a_val, b_val, px, py;
  logic                 on_scr;

  assign in_cx  = in_tdata[9:0];
  assign in_cy  = in_tdata[19:10];
  assign in_rad = in_tdata[29:20];
  assign in_col = in_tdata[38:30];

  assign in_tready = !pend_v_r || load_cur;
  assign accept    = in_tvalid && in_tready;

  // step arithmetic, modulo the decision width
  always_comb begin
    x_w     = {{(DEC_W-OFSX_W){ofs_x_r[OFSX_W-1]}}, ofs_x_r} + DEC_W'(1);
    dec_pos = !dec_r[DEC_W-1] && (dec_r != '0);
    y_w     = {{(DEC_W-OFSY_W){ofs_y_r[OFSY_W-1]}}, ofs_y_r} - DEC_W'(dec_pos);
    step_x  = x_w[OFSX_W-1:0];
    step_y  = y_w[OFSY_W-1:0];
    step_done = $signed(step_y) < $signed({step_x[OFSX_W-1], step_x});
  end

  always_comb begin
    active_nxt = active_r;
    ofs_x_nxt  = ofs_x_r;
    ofs_y_nxt  = ofs_y_r;
    dec_nxt    = dec_r;
    cx_nxt     = cx_r;
    cy_nxt     = cy_r;
    color_nxt  = color_r;
    job        = '0;
    job.status = ST_OK;
    if (in_tuser == CMD_START) begin
      if (in_col > COLOR_MAX) begin
        job.status = ST_COLOR;
        job.err    = 1'b1;
      end else if (in_cx > COORD_W'(DISPLAY_WIDTH) || in_cy > COORD_W'(DISPLAY_HEIGHT)) begin
        job.status = ST_BOUNDS;
        job.err    = 1'b1;
      end else begin
        active_nxt = 1'b1;
        ofs_x_nxt  = '0;
        ofs_y_nxt  = {{(OFSY_W-COORD_W){1'b0}}, in_rad};
        dec_nxt    = DEC_INIT - {{(DEC_W-COORD_W-1){1'b0}}, in_rad, 1'b0};
        cx_nxt     = in_cx;
        cy_nxt     = in_cy;
        color_nxt  = in_col[COLOR_W-1:0];
      end
    end else begin
      if (!active_r) begin
        job.status = ST_IDLE;
        job.err    = 1'b1;
      end else begin
        ofs_x_nxt = step_x;
        ofs_y_nxt = step_y;
        if (dec_pos) begin
          dec_nxt = dec_r + ((x_w - y_w) << 2) + DEC_DIAG;
        end else begin
          dec_nxt = dec_r + (x_w << 2) + DEC_AXIS;
        end
        job.done = step_done;
        if (step_done) begin
          active_nxt = 1'b0;
        end
      end
    end
    if (!job.err) begin
      job.cx    = cx_nxt;
      job.cy    = cy_nxt;
      job.ofs_x = ofs_x_nxt;
      job.ofs_y = ofs_y_nxt;
      job.color = color_nxt;
    end
    if (!accept || job.err) begin
      active_nxt = active_r;
      ofs_x_nxt  = ofs_x_r;
      ofs_y_nxt  = ofs_y_r;
      dec_nxt    = dec_r;
      cx_nxt     = cx_r;
      cy_nxt     = cy_r;
      color_nxt  = color_r;
    end
  end

  // emitter: one result per cycle from the current request while the output is free
  assign fire      = cur_v_r && (!out_v_r || out_tready);
  assign emit_last = cur_r.err || (idx_r == 3'd7);
  assign load_cur  = pend_v_r && (!cur_v_r || (fire && emit_last));

  always_comb begin
    pend_v_nxt = pend_v_r;
    pend_nxt   = pend_r;
    if (accept) begin
      pend_v_nxt = 1'b1;
      pend_nxt   = job;
    end else if (load_cur) begin
      pend_v_nxt = 1'b0;
    end
    cur_v_nxt = cur_v_r;
    cur_nxt   = cur_r;
    idx_nxt   = idx_r;
    if (load_cur) begin
      cur_v_nxt = 1'b1;
      cur_nxt   = pend_r;
      idx_nxt   = '0;
    end else if (fire) begin
      if (emit_last) begin
        cur_v_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 3'd1;
      end
    end
  end

  // symmetric pixel for the current index
  always_comb begin
    x12   = {cur_r.ofs_x[OFSX_W-1], cur_r.ofs_x};
    a_val = idx_r[2] ? cur_r.ofs_y : x12;
    b_val = idx_r[2] ? x12 : cur_r.ofs_y;
    px = idx_r[0] ? ({{(PIX_W-COORD_W){1'b0}}, cur_r.cx} - a_val)
                  : ({{(PIX_W-COORD_W){1'b0}}, cur_r.cx} + a_val);
    py = idx_r[1] ? ({{(PIX_W-COORD_W){1'b0}}, cur_r.cy} - b_val)
                  : ({{(PIX_W-COORD_W){1'b0}}, cur_r.cy} + b_val);
    on_scr = !px[PIX_W-1] && (px < PIX_W'(DISPLAY_WIDTH)) &&
             !py[PIX_W-1] && (py < PIX_W'(DISPLAY_HEIGHT));
  end

  always_comb begin
    out_v_nxt    = out_v_r;
    out_data_nxt = out_data_r;
    out_user_nxt = out_user_r;
    out_last_nxt = out_last_r;
    if (fire) begin
      out_v_nxt    = 1'b1;
      out_last_nxt = emit_last;
      if (cur_r.err) begin
        out_data_nxt = '0;
        out_user_nxt = {1'b0, cur_r.status};
      end else begin
        out_data_nxt = {6'd0, emit_last && cur_r.done, on_scr, cur_r.color, py, px};
        out_user_nxt = {1'b1, ST_OK};
      end
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      ofs_x_r  <= '0;
      ofs_y_r  <= '0;
      dec_r    <= '0;
      cx_r     <= '0;
      cy_r     <= '0;
      color_r  <= '0;
      pend_v_r <= 1'b0;
      cur_v_r  <= 1'b0;
      idx_r    <= '0;
      out_v_r  <= 1'b0;
    end else begin
      active_r <= active_nxt;
      ofs_x_r  <= ofs_x_nxt;
      ofs_y_r  <= ofs_y_nxt;
      dec_r    <= dec_nxt;
      cx_r     <= cx_nxt;
      cy_r     <= cy_nxt;
      color_r  <= color_nxt;
      pend_v_r <= pend_v_nxt;
      cur_v_r  <= cur_v_nxt;
      idx_r    <= idx_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r     <= pend_nxt;
    cur_r      <= cur_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== sv/bcr_checker.sv =====
// ----------------------------------------------------------------------------
// bcr_checker
// Port-level checks for the circle rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
module bcr_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [bcr_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input logic [bcr_pkg::OUT_TUSER_W-1:0]    out_tuser,
  input logic                               out_tlast
);
  import bcr_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  // error results are single, pixel-free and zeroed
  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1:0] != ST_OK |-> out_tlast && !out_tuser[2] &&
    out_tdata == '0)
    else $error("malformed status result");

  // done flag only on the final pixel of a request
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[33] |-> out_tlast && out_tuser[2])
    else $error("circle done off the last pixel");

  // on-screen pixels have non-negative coordinates
  a_onscreen: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[32] |-> !out_tdata[11] && !out_tdata[23])
    else $error("negative pixel marked on screen");

  // nothing leaves the block right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind bresenham_circle_raster bcr_checker u_bcr_checker (.*);
